// ===== rtl/core/gsc_pkg.sv =====
// Constants and helper functions for the GPS-seconds-to-calendar pipeline.
package gsc_pkg;

    // Field widths of one item and one result.
    localparam int unsigned GPS_W   = 32;
    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DOM_W   = 5;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned SEC_W   = 6;

    // Number of register stages from start to result strobe.
    localparam int unsigned PIPE_DEPTH = 9;

    // Seconds per day is 2^7 * 675; the shift strips the power of two.
    localparam int unsigned DAY_SHIFT = 7;
    localparam logic [9:0]  DAY_ODD   = 10'd675;
    // floor(2^35 / 675): quotient estimate is low by at most one.
    localparam logic [25:0] DAY_RECIP = 26'd50903316;
    localparam int unsigned DAY_RSH   = 35;

    // Day 0 of the pipeline is 1980-01-02 after this offset.
    localparam logic [15:0] DAY_OFFSET = 16'd4;

    // Exact division by 1461 (four-year cycle) for day counts below 2^16.
    localparam logic [10:0] CYCLE_DAYS  = 11'd1461;
    localparam logic [16:0] CYCLE_RECIP = 17'd91868;
    localparam int unsigned CYCLE_RSH   = 27;

    // Exact division of seconds-of-day by 3600 as (tod >> 4) / 225.
    localparam logic [15:0] HOUR_RECIP = 16'd37283;
    localparam int unsigned HOUR_RSH   = 23;
    localparam logic [11:0] SECS_HOUR  = 12'd3600;

    // Exact division of seconds-of-hour by 60 as (rem >> 2) / 15.
    localparam logic [10:0] MIN_RECIP = 11'd1093;
    localparam int unsigned MIN_RSH   = 14;
    localparam logic [5:0]  SECS_MIN  = 6'd60;

    // Exact division of (5 * ddd + 2) by 153.
    localparam logic [12:0] MGRP_RECIP = 13'd6854;
    localparam int unsigned MGRP_RSH   = 20;

    // Calendar constants.
    localparam logic [11:0] EPOCH_YEAR  = 12'd1980;
    localparam logic [8:0]  YEAR_DAYS   = 9'd365;
    localparam logic [6:0]  FEB_CUT     = 7'd60;
    localparam logic [8:0]  MARCH_SHIFT = 9'd305;
    // Year 2100 is the only year in range divisible by 100 but not by 400.
    localparam logic [7:0]  YEAR_2100   = 8'd120;

    // First day, counted from 1 March, of month group index m: (153 * m + 2) / 5.
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] v;
        case (m)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd31;
            4'd2:    v = 9'd61;
            4'd3:    v = 9'd92;
            4'd4:    v = 9'd122;
            4'd5:    v = 9'd153;
            4'd6:    v = 9'd184;
            4'd7:    v = 9'd214;
            4'd8:    v = 9'd245;
            4'd9:    v = 9'd275;
            4'd10:   v = 9'd306;
            4'd11:   v = 9'd337;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // Calendar month from the March-based index: ((m + 2) % 12) + 1.
    function automatic logic [3:0] month_of_year(input logic [3:0] m);
        logic [3:0] v;
        if (m < 4'd10) begin
            v = m + 4'd3;
        end else begin
            v = m - 4'd9;
        end
        return v;
    endfunction

endpackage

// ===== rtl/core/gps_seconds_to_calendar.sv =====
// Pipelined conversion of a GPS second count into calendar date and time of day.
// Throughput: one item per cycle; busy is never raised, as nothing downstream stalls.
// The nine stages are set by the constant-reciprocal multiplies for days, cycles and months.
// Reset (synchronous, active low) clears the stage valid bits only; no clearing pass.
// Results are not held: each appears for exactly one cycle with o_strobe.
module gps_seconds_to_calendar (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [gsc_pkg::GPS_W-1:0]     i_gps_seconds,
    output logic                          o_strobe,
    output logic [gsc_pkg::YEAR_W-1:0]    o_year,
    output logic [gsc_pkg::MONTH_W-1:0]   o_month,
    output logic [gsc_pkg::DOM_W-1:0]     o_day_of_month,
    output logic [gsc_pkg::HOUR_W-1:0]    o_hour,
    output logic [gsc_pkg::MIN_W-1:0]     o_minute,
    output logic [gsc_pkg::SEC_W-1:0]     o_second_of_minute
);

    // Stage valid bits.
    logic [gsc_pkg::PIPE_DEPTH-1:0] r_vld;
    logic [gsc_pkg::PIPE_DEPTH-1:0] n_vld;

    // Stage 1: reciprocal product for the day count.
    logic [24:0] n_s1_x;
    logic [50:0] n_s1_prod;
    logic [24:0] r_s1_x;
    logic [50:0] r_s1_prod;
    logic [6:0]  r_s1_lo;

    // Stage 2: day estimate and its remainder.
    logic [15:0] n_s2_q;
    logic [25:0] n_s2_diff;
    logic [15:0] r_s2_q;
    logic [10:0] r_s2_r;
    logic [6:0]  r_s2_lo;

    // Stage 3: corrected day number and seconds of day.
    logic        n_s3_fix;
    logic [9:0]  n_s3_r;
    logic [15:0] n_s3_d;
    logic [15:0] r_s3_d;
    logic [16:0] r_s3_tod;

    // Stage 4: reciprocal products for cycle count and hour.
    logic [32:0] n_s4_cprod;
    logic [28:0] n_s4_hprod;
    logic [15:0] r_s4_d;
    logic [32:0] r_s4_cprod;
    logic [16:0] r_s4_tod;
    logic [28:0] r_s4_hprod;

    // Stage 5: cycle count, day in cycle, hour and seconds of hour.
    logic [5:0]  n_s5_cyc;
    logic [16:0] n_s5_dr;
    logic [4:0]  n_s5_hr;
    logic [16:0] n_s5_rem;
    logic [5:0]  r_s5_cyc;
    logic [10:0] r_s5_dr;
    logic [4:0]  r_s5_hr;
    logic [11:0] r_s5_rem;

    // Stage 6: year offset, day of year and minute product.
    logic [2:0]  n_s6_yoff;
    logic [10:0] n_s6_doy;
    logic [20:0] n_s6_mprod;
    logic [7:0]  r_s6_y;
    logic [8:0]  r_s6_doy;
    logic [4:0]  r_s6_hr;
    logic [11:0] r_s6_rem;
    logic [20:0] r_s6_mprod;

    // Stage 7: March-based day of year, minute and second.
    logic        n_s7_leap;
    logic [6:0]  n_s7_cut;
    logic [8:0]  n_s7_ddd;
    logic [5:0]  n_s7_mn;
    logic [11:0] n_s7_sc;
    logic [7:0]  r_s7_y;
    logic [8:0]  r_s7_ddd;
    logic [4:0]  r_s7_hr;
    logic [5:0]  r_s7_mn;
    logic [5:0]  r_s7_sc;

    // Stage 8: month group product.
    logic [10:0] n_s8_x;
    logic [23:0] n_s8_prod;
    logic [7:0]  r_s8_y;
    logic [8:0]  r_s8_ddd;
    logic [23:0] r_s8_prod;
    logic [4:0]  r_s8_hr;
    logic [5:0]  r_s8_mn;
    logic [5:0]  r_s8_sc;

    // Stage 9: result registers.
    logic [3:0]  n_s9_m;
    logic [8:0]  n_s9_dom;
    logic [gsc_pkg::YEAR_W-1:0]  r_year;
    logic [gsc_pkg::MONTH_W-1:0] r_month;
    logic [gsc_pkg::DOM_W-1:0]   r_dom;
    logic [gsc_pkg::HOUR_W-1:0]  r_hour;
    logic [gsc_pkg::MIN_W-1:0]   r_minute;
    logic [gsc_pkg::SEC_W-1:0]   r_second;

    // The pipeline never stalls, so an item is taken on every start.
    assign busy = 1'b0;

    // Valid bits shift one stage per cycle.
    assign n_vld = {r_vld[gsc_pkg::PIPE_DEPTH-2:0], start & ~busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Stage 1: strip the power-of-two factor of 86400, multiply by 1/675.
    always_comb begin
        n_s1_x    = i_gps_seconds[gsc_pkg::GPS_W-1:gsc_pkg::DAY_SHIFT];
        n_s1_prod = 51'(n_s1_x) * 51'(gsc_pkg::DAY_RECIP);
    end

    // Stage 2: the estimate may be one low; keep the remainder to fix it.
    always_comb begin
        n_s2_q    = r_s1_prod[gsc_pkg::DAY_RSH +: 16];
        n_s2_diff = 26'(r_s1_x) - 26'(n_s2_q) * 26'(gsc_pkg::DAY_ODD);
    end

    // Stage 3: correct the quotient and rebuild the seconds of the day.
    always_comb begin
        n_s3_fix = (r_s2_r >= 11'(gsc_pkg::DAY_ODD));
        n_s3_r   = n_s3_fix ? 10'(r_s2_r - 11'(gsc_pkg::DAY_ODD)) : r_s2_r[9:0];
        n_s3_d   = r_s2_q + 16'(n_s3_fix) + gsc_pkg::DAY_OFFSET;
    end

    // Stage 4: reciprocal products for the four-year cycle and the hour.
    always_comb begin
        n_s4_cprod = 33'(r_s3_d) * 33'(gsc_pkg::CYCLE_RECIP);
        n_s4_hprod = 29'(r_s3_tod[16:4]) * 29'(gsc_pkg::HOUR_RECIP);
    end

    // Stage 5: cycle count and day within it; hour and leftover seconds.
    always_comb begin
        n_s5_cyc = r_s4_cprod[gsc_pkg::CYCLE_RSH +: 6];
        n_s5_dr  = 17'(r_s4_d) - 17'(n_s5_cyc) * 17'(gsc_pkg::CYCLE_DAYS);
        n_s5_hr  = r_s4_hprod[gsc_pkg::HOUR_RSH +: 5];
        n_s5_rem = r_s4_tod - 17'(n_s5_hr) * 17'(gsc_pkg::SECS_HOUR);
    end

    // Stage 6: year within the cycle, one-based day of year and minute product.
    always_comb begin
        n_s6_yoff = 3'(r_s5_dr >= 11'd365) + 3'(r_s5_dr >= 11'd730)
                  + 3'(r_s5_dr >= 11'd1095) + 3'(r_s5_dr >= 11'd1460);
        // Start of year within the cycle: yoff * 365 plus one leap day after year 0.
        n_s6_doy  = r_s5_dr + 11'd2 - 11'((n_s6_yoff + 3'd3) >> 2)
                  - 11'(n_s6_yoff) * 11'(gsc_pkg::YEAR_DAYS);
        n_s6_mprod = 21'(r_s5_rem[11:2]) * 21'(gsc_pkg::MIN_RECIP);
    end

    // Stage 7: shift the day count to a year that starts on 1 March; split minute and second.
    always_comb begin
        n_s7_leap = (r_s6_y[1:0] == 2'd0) && (r_s6_y != gsc_pkg::YEAR_2100);
        n_s7_cut  = gsc_pkg::FEB_CUT + 7'(n_s7_leap);
        if (r_s6_doy < 9'(n_s7_cut)) begin
            n_s7_ddd = r_s6_doy + gsc_pkg::MARCH_SHIFT;
        end else begin
            n_s7_ddd = r_s6_doy - 9'(n_s7_cut);
        end
        n_s7_mn = r_s6_mprod[gsc_pkg::MIN_RSH +: 6];
        n_s7_sc = r_s6_rem - 12'(n_s7_mn) * 12'(gsc_pkg::SECS_MIN);
    end

    // Stage 8: month group product for (5 * ddd + 2) / 153.
    always_comb begin
        n_s8_x    = 11'(r_s7_ddd) * 11'd5 + 11'd2;
        n_s8_prod = 24'(n_s8_x) * 24'(gsc_pkg::MGRP_RECIP);
    end

    // Stage 9: month index, day of month and calendar year.
    always_comb begin
        n_s9_m   = r_s8_prod[gsc_pkg::MGRP_RSH +: 4];
        n_s9_dom = r_s8_ddd - gsc_pkg::month_start(n_s9_m) + 9'd1;
    end

    // Payload registers of all stages.
    always_ff @(posedge i_clk) begin
        r_s1_x     <= n_s1_x;
        r_s1_prod  <= n_s1_prod;
        r_s1_lo    <= i_gps_seconds[gsc_pkg::DAY_SHIFT-1:0];

        r_s2_q     <= n_s2_q;
        r_s2_r     <= n_s2_diff[10:0];
        r_s2_lo    <= r_s1_lo;

        r_s3_d     <= n_s3_d;
        r_s3_tod   <= {n_s3_r, r_s2_lo};

        r_s4_d     <= r_s3_d;
        r_s4_cprod <= n_s4_cprod;
        r_s4_tod   <= r_s3_tod;
        r_s4_hprod <= n_s4_hprod;

        r_s5_cyc   <= n_s5_cyc;
        r_s5_dr    <= n_s5_dr[10:0];
        r_s5_hr    <= n_s5_hr;
        r_s5_rem   <= n_s5_rem[11:0];

        r_s6_y     <= {r_s5_cyc, 2'b00} + 8'(n_s6_yoff);
        r_s6_doy   <= n_s6_doy[8:0];
        r_s6_hr    <= r_s5_hr;
        r_s6_rem   <= r_s5_rem;
        r_s6_mprod <= n_s6_mprod;

        r_s7_y     <= r_s6_y;
        r_s7_ddd   <= n_s7_ddd;
        r_s7_hr    <= r_s6_hr;
        r_s7_mn    <= n_s7_mn;
        r_s7_sc    <= n_s7_sc[5:0];

        r_s8_y     <= r_s7_y;
        r_s8_ddd   <= r_s7_ddd;
        r_s8_prod  <= n_s8_prod;
        r_s8_hr    <= r_s7_hr;
        r_s8_mn    <= r_s7_mn;
        r_s8_sc    <= r_s7_sc;

        r_year     <= gsc_pkg::EPOCH_YEAR + 12'(r_s8_y);
        r_month    <= gsc_pkg::month_of_year(n_s9_m);
        r_dom      <= n_s9_dom[4:0];
        r_hour     <= r_s8_hr;
        r_minute   <= r_s8_mn;
        r_second   <= r_s8_sc;
    end

    // Result ports.
    assign o_strobe           = r_vld[gsc_pkg::PIPE_DEPTH-1];
    assign o_year             = r_year;
    assign o_month            = r_month;
    assign o_day_of_month     = r_dom;
    assign o_hour             = r_hour;
    assign o_minute           = r_minute;
    assign o_second_of_minute = r_second;

    // Every accepted item yields its result with o_strobe.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##9 o_strobe)
        else $error("item taken without a result nine cycles later");

    // The rebuilt seconds of the day stay below 86400, so the corrected remainder stays below 675.
    a_day_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r_s3_tod < 17'd86400))
        else $error("seconds of day out of range");

    // The March-based day of year stays within one year.
    a_doy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[6] |-> (r_s7_ddd < 9'd366))
        else $error("March-based day of year out of range");

    // Month of a result stays within 1 to 12 and day of month is at least 1.
    a_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_month >= 4'd1 && o_month <= 4'd12
                      && o_day_of_month >= 5'd1))
        else $error("month or day of month out of range");

    // Time fields of a result stay within their ranges.
    a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_hour < 5'd24 && o_minute < 6'd60
                      && o_second_of_minute < 6'd60))
        else $error("time of day out of range");

endmodule
